// ===== rtl/thermistor_table_interpolation_unit_macros.svh =====
// Assertion macros for the thermistor table interpolation unit.
`ifndef THERMISTOR_TABLE_INTERPOLATION_UNIT_MACROS_SVH
`define THERMISTOR_TABLE_INTERPOLATION_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TTI_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("tti: assertion failed");
`define TTI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tti: assertion failed");
`else
`define TTI_ASSERT(name, expr)
`define TTI_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== rtl/tti_pkg.sv =====
// Package: types and constants of the thermistor table interpolation unit.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

  localparam int AdcW   = 10;
  localparam int TempW  = 12;
  localparam int CfgW   = 6;
  localparam int IdxW   = 5;
  localparam int ProdW  = 23;
  localparam int DvdW   = 23;
  localparam int DvsW   = 11;
  localparam int QuoW   = 12;
  localparam int DivCntW = 4;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_CONVERT = 1'b1
  } tti_mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ABOVE = 2'd2
  } tti_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_DIVGO,
    ST_DIV,
    ST_DONE
  } tti_state_e;

  typedef struct packed {
    logic                    mode;
    logic [IdxW-1:0]         entry_index;
    logic [AdcW-1:0]         entry_adc;
    logic signed [TempW-1:0] entry_temperature;
    logic [AdcW-1:0]         adc_value;
  } tti_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_tenths;
    logic [1:0]              status;
  } tti_out_t;

  typedef struct packed {
    logic [AdcW-1:0]         adc;
    logic signed [TempW-1:0] temp;
  } tti_row_t;

endpackage

`default_nettype wire

// ===== rtl/tti_cell.sv =====
// Table cell: holds one row, loads it, or takes its neighbor's row on a shift.
`timescale 1ns / 1ps
`default_nettype none

module tti_cell
  import tti_pkg::*;
(
  input  logic     clk_i,
  input  logic     load_i,
  input  tti_row_t load_row_i,
  input  logic     shift_i,
  input  tti_row_t next_row_i,
  output tti_row_t row_o
);

  tti_row_t row_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= load_row_i;
    end else if (shift_i) begin
      row_q <= next_row_i;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

// ===== rtl/tti_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tti_div
  import tti_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [QuoW-1:0] quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW:0]      rem_q;
  logic [QuoW-1:0]    dvd_q;
  logic [DvsW-1:0]    dvs_q;
  logic [QuoW-1:0]    quo_q;
  logic [DvsW:0]      trial;
  logic               fits;

  // quotient is known to fit QuoW bits, so the top dividend bits start below the divisor
  assign trial = {rem_q[DvsW-1:0], dvd_q[QuoW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[DvdW-1:QuoW]};
      dvd_q <= dividend_i[QuoW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
      dvd_q <= {dvd_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/thermistor_table_interpolation_unit.sv =====
// Top level: thermistor ADC to temperature by table scan and linear interpolation.
//
//  port group     | dir | handshake                 | word
//  start/in_word  | in  | start_i & !busy_o         | tti_in_t (load or convert)
//  res_valid/word | out | res_valid_o, one cycle    | tti_out_t
//  cfg_we/wdata   | in  | cfg_we_i                  | entries_in_use
//
// A load word is written into its cell when it is accepted and gives no result.
// A convert word rotates the cell chain once, one row per cycle.
// Exact match or out of range: the scan goes straight to ST_DONE, which strobes the result.
// Interpolation: the scan is followed by multiply, sum, setup, divider load and the divider steps.
// Reset clears control only; table rows are undefined until loaded.
// Results are shown for one cycle, then busy_o falls; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "thermistor_table_interpolation_unit_macros.svh"

module thermistor_table_interpolation_unit
  import tti_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  tti_in_t         in_word_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            res_valid_o,
  output tti_out_t        res_word_o
);

  localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NW = $clog2(TABLE_ENTRIES + 1);

  tti_state_e state_q, state_d;

  logic [CfgW-1:0] cfg_q;
  logic [SW-1:0]   step_q;
  logic            found_q;
  logic            exact_q;

  logic [NW-1:0]   n_clamp;
  logic [NW-1:0]   n_q;
  logic [AdcW-1:0] adc_q;
  logic            below_q;
  logic [AdcW-1:0] a0_q, a1_q, den_q;
  logic signed [TempW-1:0] t0_q, t1_q, temp_q;
  logic [1:0]      status_q;
  logic signed [ProdW-1:0] p0_q, p1_q, num_q;
  logic            neg_q;
  logic [DvdW-1:0] dvd_q;
  logic [AdcW-1:0] d0, d1;
  logic [ProdW-2:0] mag;

  logic            accept;
  logic            load_go;
  logic            conv_go;
  logic            shift;
  logic            last_step;
  logic            scan_live;
  logic            has_next;
  logic            hit_exact;
  logic            hit_brk;
  logic            div_start;
  logic            div_done;
  logic [QuoW-1:0] quo;
  logic signed [TempW-1:0] quo_s;

  tti_row_t               load_row;
  tti_row_t               rows [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_we;

  assign accept  = start_i && !busy_o;
  assign load_go = accept && (in_word_i.mode == MODE_LOAD);
  assign conv_go = accept && (in_word_i.mode == MODE_CONVERT);
  assign shift   = (state_q == ST_SCAN);
  assign load_row.adc  = in_word_i.entry_adc;
  assign load_row.temp = in_word_i.entry_temperature;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    assign cell_we[k] = load_go && (32'(in_word_i.entry_index) == k);
    tti_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (cell_we[k]),
      .load_row_i (load_row),
      .shift_i    (shift),
      .next_row_i (rows[(k + 1) % TABLE_ENTRIES]),
      .row_o      (rows[k])
    );
  end

  always_comb begin
    if (cfg_q < CfgW'(2)) begin
      n_clamp = NW'(2);
    end else if (32'(cfg_q) > TABLE_ENTRIES) begin
      n_clamp = NW'(TABLE_ENTRIES);
    end else begin
      n_clamp = NW'(cfg_q);
    end
  end

  // rows[0] holds row step_q, rows[1] holds row step_q + 1
  assign last_step = (step_q == SW'(TABLE_ENTRIES - 1));
  assign scan_live = !found_q && ((NW + 1)'(step_q) < (NW + 1)'(n_q));
  assign has_next  = ((NW + 1)'(step_q) + 1'b1) < (NW + 1)'(n_q);
  assign hit_exact = shift && scan_live && (rows[0].adc == adc_q);
  assign hit_brk   = shift && scan_live && !(rows[0].adc == adc_q) && has_next &&
                     (rows[0].adc < adc_q) && (rows[1].adc > adc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CfgW'(32);
      step_q  <= '0;
      found_q <= 1'b0;
      exact_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (conv_go) begin
        step_q  <= '0;
        found_q <= 1'b0;
        exact_q <= 1'b0;
      end else if (shift) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
        if (hit_exact || hit_brk) begin
          found_q <= 1'b1;
          exact_q <= hit_exact;
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (conv_go) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          if ((found_q && !exact_q) || hit_brk) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIVGO;
      ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign d0    = a1_q - adc_q;
  assign d1    = adc_q - a0_q;
  assign mag   = (ProdW - 1)'(num_q[ProdW-1] ? -num_q : num_q);
  assign quo_s = signed'(quo);

  always_ff @(posedge clk_i) begin
    if (conv_go) begin
      adc_q <= in_word_i.adc_value;
      n_q   <= n_clamp;
    end
    if (shift) begin
      if (step_q == '0) begin
        below_q <= adc_q < rows[0].adc;
      end
      if (hit_exact || hit_brk) begin
        a0_q <= rows[0].adc;
        a1_q <= rows[1].adc;
        t0_q <= rows[0].temp;
        t1_q <= rows[1].temp;
      end
      if (last_step) begin
        status_q <= STAT_OK;
        if (hit_exact) begin
          temp_q <= rows[0].temp;
        end else if (found_q && exact_q) begin
          temp_q <= t0_q;
        end else if (!found_q && !hit_brk) begin
          temp_q   <= '0;
          status_q <= below_q ? STAT_BELOW : STAT_ABOVE;
        end
      end
    end
    if (state_q == ST_MUL) begin
      p0_q <= t0_q * signed'({1'b0, d0});
      p1_q <= t1_q * signed'({1'b0, d1});
    end
    if (state_q == ST_SUM) begin
      num_q <= p0_q + p1_q;
      den_q <= a1_q - a0_q;
    end
    if (state_q == ST_PREP) begin
      neg_q <= num_q[ProdW-1];
      dvd_q <= {mag, 1'b0} + DvdW'(den_q);
    end
    if (state_q == ST_DIV && div_done) begin
      temp_q <= neg_q ? -quo_s : quo_s;
    end
  end

  tti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  ({den_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign busy_o                        = (state_q != ST_IDLE);
  assign res_valid_o                   = (state_q == ST_DONE);
  assign res_word_o.temperature_tenths = temp_q;
  assign res_word_o.status             = status_q;

  `TTI_ASSERT_NEXT(a_strobe_single, res_valid_o, !res_valid_o)
  `TTI_ASSERT(a_result_while_busy, !res_valid_o || busy_o)
  `TTI_ASSERT_NEXT(a_convert_busy, conv_go, busy_o)
  `TTI_ASSERT(a_flag_zero, !res_valid_o || status_q == STAT_OK || temp_q == '0)

endmodule

`default_nettype wire
